>>> src/cbms_pkg.sv
// ----------------------------------------------------------------------------
// cbms_pkg
// Shared constants for the blob moment statistics block: image size limits,
// register indexes, covariance saturation limit and the arctangent table of
// the angle unit.
// ----------------------------------------------------------------------------
package cbms_pkg;

    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 256;

    localparam logic [2:0] CFG_TARGET_LABEL  = 3'd0;
    localparam logic [2:0] CFG_IMAGE_ROWS    = 3'd1;
    localparam logic [2:0] CFG_IMAGE_COLS    = 3'd2;
    localparam logic [2:0] CFG_BOX_ROW_FIRST = 3'd3;
    localparam logic [2:0] CFG_BOX_ROW_LAST  = 3'd4;
    localparam logic [2:0] CFG_BOX_COL_FIRST = 3'd5;
    localparam logic [2:0] CFG_BOX_COL_LAST  = 3'd6;

    localparam logic [63:0] COV_SAT      = 64'd1073741823;
    localparam logic signed [19:0] PI_HALF_Q16 = 20'sd102944;
    localparam logic signed [16:0] ANGLE_MAX   = 17'sd25736;

    typedef logic signed [39:0] t_vec;

    function automatic logic signed [19:0] atan_q16(input logic [3:0] idx);
        logic signed [19:0] v;
        case (idx)
            4'd0:  v = 20'sd51472;
            4'd1:  v = 20'sd30386;
            4'd2:  v = 20'sd16055;
            4'd3:  v = 20'sd8150;
            4'd4:  v = 20'sd4091;
            4'd5:  v = 20'sd2047;
            4'd6:  v = 20'sd1024;
            4'd7:  v = 20'sd512;
            4'd8:  v = 20'sd256;
            4'd9:  v = 20'sd128;
            4'd10: v = 20'sd64;
            4'd11: v = 20'sd32;
            4'd12: v = 20'sd16;
            4'd13: v = 20'sd8;
            4'd14: v = 20'sd4;
            default: v = 20'sd2;
        endcase
        return v;
    endfunction

    // magnitude below 2^32
    function automatic logic mag_small(input t_vec v);
        logic res;
        if (!v[39]) begin
            res = (v[39:32] == 8'd0);
        end else begin
            res = (v[39:32] == 8'hFF) && (v[31:0] != 32'd0);
        end
        return res;
    endfunction

endpackage

>>> src/color_blob_moment_statistics.sv
// ----------------------------------------------------------------------------
// color_blob_moment_statistics
// Accepts one pixel label per cycle while a frame streams in. On the last
// pixel, a sequencer runs the moment math through one 32x32 multiplier, a
// one-bit-per-cycle divider, a two-bit-per-cycle root unit and a CORDIC step.
// After the last pixel of a nonempty blob: five 64-step divisions, three
// 32-step roots, up to 32 normalize steps and 16 angle steps; an empty blob
// goes straight to the output. Pixels are stalled meanwhile and while a
// finished beat waits on the output.
// Reset is synchronous, active low; it restores the register defaults and
// clears counters and accumulators.
// ----------------------------------------------------------------------------
module color_blob_moment_statistics
    import cbms_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_pixel_label,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_blob_found,
    output logic [16:0]        o_area,
    output logic [15:0]        o_centroid_row,
    output logic [15:0]        o_centroid_col,
    output logic [7:0]         o_min_row,
    output logic [7:0]         o_max_row,
    output logic [7:0]         o_min_col,
    output logic [7:0]         o_max_col,
    output logic [17:0]        o_major_axis,
    output logic [17:0]        o_minor_axis,
    output logic signed [15:0] o_orientation,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    output logic               o_cfg_ready
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);

    localparam logic [3:0] ST_RUN  = 4'd0;
    localparam logic [3:0] ST_CS   = 4'd1;
    localparam logic [3:0] ST_MP   = 4'd2;
    localparam logic [3:0] ST_MQ   = 4'd3;
    localparam logic [3:0] ST_MD   = 4'd4;
    localparam logic [3:0] ST_DS   = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_F1   = 4'd7;
    localparam logic [3:0] ST_F2   = 4'd8;
    localparam logic [3:0] ST_SS   = 4'd9;
    localparam logic [3:0] ST_SQ   = 4'd10;
    localparam logic [3:0] ST_NORM = 4'd11;
    localparam logic [3:0] ST_CORD = 4'd12;
    localparam logic [3:0] ST_DONE = 4'd13;

    // configuration
    logic [7:0] r_target;
    logic [8:0] r_rows, r_cols;
    logic [7:0] r_brf, r_brl, r_bcf, r_bcl;

    // frame state
    logic [3:0]    r_state;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [16:0]   r_count;
    logic [7:0]    r_rmin, r_rmax, r_cmin, r_cmax;
    logic [23:0]   r_rsum, r_csum;
    logic [31:0]   r_rsq, r_csq, r_xsum;
    logic          r_found;

    // sequencer working registers
    logic [1:0]    r_k;
    logic          r_cov;
    logic [5:0]    r_cnt;
    logic [63:0]   r_prod, r_p, r_q;
    logic [63:0]   r_num;
    logic [34:0]   r_rem;
    logic [33:0]   r_div;
    logic          r_neg;
    logic [63:0]   r_sv, r_sr, r_sb;
    logic [15:0]   r_cent_row, r_cent_col;
    logic [29:0]   r_cxx, r_cyy, r_cxy_mag;
    logic          r_cxy_neg;
    logic [33:0]   r_lmin2;
    logic [17:0]   r_major, r_minor;
    t_vec          r_x, r_y;
    logic signed [19:0] r_z;
    logic signed [15:0] r_orient;

    // effective image size
    logic [15:0]   eff_r, eff_c;
    logic [RW-1:0] last_r;
    logic [CW-1:0] last_c;
    logic [7:0]    rmin_init, cmin_init;

    always_comb begin
        if (r_rows == 9'd0) begin
            eff_r = 16'd1;
        end else if (16'(r_rows) > 16'(MAX_ROWS)) begin
            eff_r = 16'(MAX_ROWS);
        end else begin
            eff_r = 16'(r_rows);
        end
        if (r_cols == 9'd0) begin
            eff_c = 16'd1;
        end else if (16'(r_cols) > 16'(MAX_COLS)) begin
            eff_c = 16'(MAX_COLS);
        end else begin
            eff_c = 16'(r_cols);
        end
        last_r    = RW'(eff_r - 16'd1);
        last_c    = CW'(eff_c - 16'd1);
        rmin_init = (eff_r - 16'd1 > 16'd255) ? 8'd255 : 8'(eff_r - 16'd1);
        cmin_init = (eff_c - 16'd1 > 16'd255) ? 8'd255 : 8'(eff_c - 16'd1);
    end

    // pixel path
    logic       px_acc, hit, frame_end;
    logic [7:0] rb, cb;
    logic [16:0] n_count;

    assign px_acc = i_valid && (r_state == ST_RUN);
    assign rb     = 8'(r_row);
    assign cb     = 8'(r_col);
    assign hit    = (i_pixel_label == r_target)
                    && (16'(r_row) >= 16'(r_brf)) && (16'(r_row) <= 16'(r_brl))
                    && (16'(r_col) >= 16'(r_bcf)) && (16'(r_col) <= 16'(r_bcl));
    assign frame_end = (r_row >= last_r) && (r_col >= last_c);
    assign n_count   = hit ? r_count + 17'd1 : r_count;

    // shared multiplier operands
    logic [31:0] mul_x, mul_y, s2, s1a, s1b;
    logic [29:0] dd;

    always_comb begin
        case (r_k)
            2'd0:    s2 = r_rsq;
            2'd1:    s2 = r_csq;
            default: s2 = r_xsum;
        endcase
        s1a = (r_k == 2'd1) ? 32'(r_csum) : 32'(r_rsum);
        s1b = (r_k == 2'd0) ? 32'(r_rsum) : 32'(r_csum);
        dd  = (r_cxx >= r_cyy) ? r_cxx - r_cyy : r_cyy - r_cxx;
        mul_x = 32'd0;
        mul_y = 32'd0;
        unique case (r_state)
            ST_MP: begin
                mul_x = 32'(r_count);
                mul_y = s2;
            end
            ST_MQ: begin
                mul_x = s1a;
                mul_y = s1b;
            end
            ST_MD: begin
                mul_x = 32'(r_count);
                mul_y = 32'(r_count);
            end
            ST_F1: begin
                mul_x = 32'(dd);
                mul_y = 32'(dd);
            end
            ST_F2: begin
                mul_x = 32'(r_cxy_mag);
                mul_y = 32'(r_cxy_mag);
            end
            default: begin
                mul_x = 32'd0;
                mul_y = 32'd0;
            end
        endcase
    end

    // divider step
    logic [34:0] dv_t;
    logic        dv_bit;
    logic [34:0] n_rem;
    logic [63:0] n_num;

    always_comb begin
        dv_t   = {r_rem[33:0], r_num[63]};
        dv_bit = (dv_t >= {1'b0, r_div});
        n_rem  = dv_bit ? dv_t - {1'b0, r_div} : dv_t;
        n_num  = {r_num[62:0], dv_bit};
    end

    // root step
    logic [63:0] sq_sum, n_sv, n_sr;

    always_comb begin
        sq_sum = r_sr + r_sb;
        if (r_sv >= sq_sum) begin
            n_sv = r_sv - sq_sum;
            n_sr = (r_sr >> 1) + r_sb;
        end else begin
            n_sv = r_sv;
            n_sr = r_sr >> 1;
        end
    end

    // covariance finish, eigenvalues, angle inputs
    logic [29:0] cov_m;
    logic [30:0] tr;
    logic [33:0] lmax2, lmin2;
    logic [36:0] six_lmax, six_lmin;
    logic [19:0] axis_sum;
    logic [17:0] axis_val;
    t_vec        cxy_s, ox, oy;

    always_comb begin
        cov_m    = (n_num > COV_SAT) ? 30'(COV_SAT) : n_num[29:0];
        tr       = 31'(r_cxx) + 31'(r_cyy);
        lmax2    = 34'(tr) + n_sr[33:0];
        lmin2    = (34'(tr) > n_sr[33:0]) ? 34'(tr) - n_sr[33:0] : 34'd0;
        six_lmax = (37'(lmax2) << 2) + (37'(lmax2) << 1);
        six_lmin = (37'(r_lmin2) << 2) + (37'(r_lmin2) << 1);
        axis_sum = n_sr[19:0] + 20'd128;
        axis_val = (axis_sum > 20'd262143) ? 18'd262143 : axis_sum[17:0];
        cxy_s    = r_cxy_neg ? -t_vec'({10'd0, r_cxy_mag}) : t_vec'({10'd0, r_cxy_mag});
        oy       = t_vec'({9'd0, r_cyy, 1'b0}) - (cxy_s <<< 1) - t_vec'({6'd0, r_lmin2});
        ox       = t_vec'({9'd0, r_cxx, 1'b0}) - (cxy_s <<< 1) - t_vec'({6'd0, r_lmin2});
    end

    // angle step
    t_vec               xs, ys;
    logic signed [19:0] zr;
    logic signed [16:0] zq;
    logic signed [15:0] zc;

    always_comb begin
        xs = r_x >>> r_cnt[3:0];
        ys = r_y >>> r_cnt[3:0];
        zr = (r_y > 0) ? r_z + atan_q16(r_cnt[3:0]) : r_z - atan_q16(r_cnt[3:0]);
        zq = 17'((zr + 20'sd4) >>> 3);
        if (zq > ANGLE_MAX) begin
            zc = 16'(ANGLE_MAX);
        end else if (zq < -ANGLE_MAX) begin
            zc = 16'(-ANGLE_MAX);
        end else begin
            zc = 16'(zq);
        end
    end

    assign o_stall     = (r_state != ST_RUN);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_x) * 64'(mul_y);
        if (!i_rst_n) begin
            r_target <= 8'd1;
            r_rows   <= 9'd256;
            r_cols   <= 9'd256;
            r_brf    <= 8'd0;
            r_brl    <= 8'd255;
            r_bcf    <= 8'd0;
            r_bcl    <= 8'd255;
            r_state  <= ST_RUN;
            r_row    <= '0;
            r_col    <= '0;
            r_count  <= '0;
            r_rmin   <= 8'd255;
            r_rmax   <= '0;
            r_cmin   <= 8'd255;
            r_cmax   <= '0;
            r_rsum   <= '0;
            r_csum   <= '0;
            r_rsq    <= '0;
            r_csq    <= '0;
            r_xsum   <= '0;
            r_found  <= 1'b0;
            r_k      <= '0;
            r_cov    <= 1'b0;
            r_cnt    <= '0;
            o_valid  <= 1'b0;
        end else begin
            if (o_valid && !i_stall && (r_state != ST_DONE)) begin
                o_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TARGET_LABEL:  r_target <= i_cfg_data[7:0];
                    CFG_IMAGE_ROWS:    r_rows   <= i_cfg_data;
                    CFG_IMAGE_COLS:    r_cols   <= i_cfg_data;
                    CFG_BOX_ROW_FIRST: r_brf    <= i_cfg_data[7:0];
                    CFG_BOX_ROW_LAST:  r_brl    <= i_cfg_data[7:0];
                    CFG_BOX_COL_FIRST: r_bcf    <= i_cfg_data[7:0];
                    CFG_BOX_COL_LAST:  r_bcl    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_RUN: begin
                    if (px_acc) begin
                        if (hit) begin
                            r_count <= n_count;
                            if (rb < r_rmin) r_rmin <= rb;
                            if (rb > r_rmax) r_rmax <= rb;
                            if (cb < r_cmin) r_cmin <= cb;
                            if (cb > r_cmax) r_cmax <= cb;
                            r_rsum <= r_rsum + 24'(rb);
                            r_csum <= r_csum + 24'(cb);
                            r_rsq  <= r_rsq + 32'(16'(rb) * 16'(rb));
                            r_csq  <= r_csq + 32'(16'(cb) * 16'(cb));
                            r_xsum <= r_xsum + 32'(16'(rb) * 16'(cb));
                        end
                        if (frame_end) begin
                            r_row   <= '0;
                            r_col   <= '0;
                            r_found <= (n_count != 17'd0);
                            r_k     <= 2'd0;
                            r_state <= (n_count == 17'd0) ? ST_DONE : ST_CS;
                        end else if (r_row >= last_r) begin
                            r_row <= '0;
                            r_col <= r_col + CW'(1);
                        end else begin
                            r_row <= r_row + RW'(1);
                        end
                    end
                end
                ST_CS: begin
                    r_num   <= {30'd0, (34'(r_k[0] ? r_csum : r_rsum) << 9) + 34'(r_count)};
                    r_div   <= {16'd0, r_count, 1'b0};
                    r_rem   <= '0;
                    r_cnt   <= 6'd63;
                    r_cov   <= 1'b0;
                    r_state <= ST_DIV;
                end
                ST_MP: begin
                    r_state <= ST_MQ;
                end
                ST_MQ: begin
                    r_p     <= r_prod;
                    r_state <= ST_MD;
                end
                ST_MD: begin
                    r_q     <= r_prod;
                    r_state <= ST_DS;
                end
                ST_DS: begin
                    r_neg   <= (r_p < r_q);
                    r_num   <= ((r_p < r_q) ? r_q - r_p : r_p - r_q) << 16;
                    r_div   <= r_prod[33:0];
                    r_rem   <= '0;
                    r_cnt   <= 6'd63;
                    r_cov   <= 1'b1;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_num <= n_num;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        if (!r_cov) begin
                            if (r_k[0]) begin
                                r_cent_col <= (n_num > 64'd65535) ? 16'hFFFF : n_num[15:0];
                                r_k        <= 2'd0;
                                r_state    <= ST_MP;
                            end else begin
                                r_cent_row <= (n_num > 64'd65535) ? 16'hFFFF : n_num[15:0];
                                r_k        <= 2'd1;
                                r_state    <= ST_CS;
                            end
                        end else begin
                            case (r_k)
                                2'd0: r_cxx <= r_neg ? 30'd0 : cov_m;
                                2'd1: r_cyy <= r_neg ? 30'd0 : cov_m;
                                default: begin
                                    r_cxy_mag <= cov_m;
                                    r_cxy_neg <= r_neg && (cov_m != 30'd0);
                                end
                            endcase
                            if (r_k == 2'd2) begin
                                r_state <= ST_F1;
                            end else begin
                                r_k     <= r_k + 2'd1;
                                r_state <= ST_MP;
                            end
                        end
                    end
                end
                ST_F1: begin
                    r_state <= ST_F2;
                end
                ST_F2: begin
                    r_p     <= r_prod;
                    r_state <= ST_SS;
                end
                ST_SS: begin
                    r_sv    <= r_p + (r_prod << 2);
                    r_sr    <= '0;
                    r_sb    <= 64'd1 << 62;
                    r_cnt   <= 6'd31;
                    r_k     <= 2'd0;
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    if (r_cnt != 6'd0) begin
                        r_sv  <= n_sv;
                        r_sr  <= n_sr;
                        r_sb  <= r_sb >> 2;
                        r_cnt <= r_cnt - 6'd1;
                    end else begin
                        r_sr  <= '0;
                        r_sb  <= 64'd1 << 62;
                        r_cnt <= 6'd31;
                        case (r_k)
                            2'd0: begin
                                r_lmin2 <= lmin2;
                                r_sv    <= 64'(six_lmax);
                                r_k     <= 2'd1;
                            end
                            2'd1: begin
                                r_major <= axis_val;
                                r_sv    <= 64'(six_lmin);
                                r_k     <= 2'd2;
                            end
                            default: begin
                                r_minor <= axis_val;
                                r_x     <= ox;
                                r_y     <= oy;
                                r_z     <= '0;
                                if (ox == '0 && oy == '0) begin
                                    r_orient <= '0;
                                    r_state  <= ST_DONE;
                                end else begin
                                    r_state <= ST_NORM;
                                end
                            end
                        endcase
                    end
                end
                ST_NORM: begin
                    if (mag_small(r_x) && mag_small(r_y)) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        r_cnt   <= '0;
                        r_state <= ST_CORD;
                        if (r_x < 0) begin
                            if (r_y >= 0) begin
                                r_x <= r_y;
                                r_y <= -r_x;
                                r_z <= PI_HALF_Q16;
                            end else begin
                                r_x <= -r_y;
                                r_y <= r_x;
                                r_z <= -PI_HALF_Q16;
                            end
                        end
                    end
                end
                ST_CORD: begin
                    r_z   <= zr;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_y > 0) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                    end
                    if (r_cnt[3:0] == 4'd15) begin
                        r_orient <= zc;
                        r_state  <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!o_valid || !i_stall) begin
                        o_valid        <= 1'b1;
                        o_blob_found   <= r_found;
                        o_area         <= r_count;
                        o_centroid_row <= r_found ? r_cent_row : 16'd0;
                        o_centroid_col <= r_found ? r_cent_col : 16'd0;
                        o_min_row      <= r_found ? r_rmin : 8'd0;
                        o_max_row      <= r_found ? r_rmax : 8'd0;
                        o_min_col      <= r_found ? r_cmin : 8'd0;
                        o_max_col      <= r_found ? r_cmax : 8'd0;
                        o_major_axis   <= r_found ? r_major : 18'd0;
                        o_minor_axis   <= r_found ? r_minor : 18'd0;
                        o_orientation  <= r_found ? r_orient : 16'sd0;
                        r_count <= '0;
                        r_rmin  <= rmin_init;
                        r_rmax  <= '0;
                        r_cmin  <= cmin_init;
                        r_cmax  <= '0;
                        r_rsum  <= '0;
                        r_csum  <= '0;
                        r_rsq   <= '0;
                        r_csq   <= '0;
                        r_xsum  <= '0;
                        r_state <= ST_RUN;
                    end
                end
                default: r_state <= ST_RUN;
            endcase
        end
    end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Streams labeled frames into color_blob_moment_statistics and checks each
// per-frame statistics beat against a bit-exact moment predictor. Config
// writes happen only with the block idle; both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import cbms_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int SETTLE = 500;
    localparam int CYCLE_LIMIT = 5000000;

    typedef enum logic [1:0] {BEAT_PIXEL, BEAT_CFG, BEAT_DRAIN} t_beat_kind;

    typedef struct {
        t_beat_kind  kind;
        logic [2:0]  idx;
        logic [8:0]  data;
    } t_beat;

    typedef struct {
        logic               found;
        logic [16:0]        area;
        logic [15:0]        crow;
        logic [15:0]        ccol;
        logic [7:0]         rmin;
        logic [7:0]         rmax;
        logic [7:0]         cmin;
        logic [7:0]         cmax;
        logic [17:0]        major;
        logic [17:0]        minor;
        logic signed [15:0] orient;
    } t_stats;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [7:0]         i_pixel_label = 8'd0;
    logic               o_stall;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_blob_found;
    logic [16:0]        o_area;
    logic [15:0]        o_centroid_row;
    logic [15:0]        o_centroid_col;
    logic [7:0]         o_min_row;
    logic [7:0]         o_max_row;
    logic [7:0]         o_min_col;
    logic [7:0]         o_max_col;
    logic [17:0]        o_major_axis;
    logic [17:0]        o_minor_axis;
    logic signed [15:0] o_orientation;
    logic               i_cfg_valid = 1'b0;
    logic [2:0]         i_cfg_index = 3'd0;
    logic [8:0]         i_cfg_data = 9'd0;
    logic               o_cfg_ready;

    color_blob_moment_statistics dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_beat  pending[$];
    t_stats frame_stats[$];
    int     errors = 0;
    int     cycles = 0;

    // predictor state
    logic [7:0]  m_target;
    logic [8:0]  m_rows, m_cols;
    logic [7:0]  m_rfirst, m_rlast, m_cfirst, m_clast;
    int          m_row, m_col;
    logic [63:0] m_count, m_rsum, m_csum, m_rsq, m_csq, m_xsum;
    logic [7:0]  m_rmin, m_rmax, m_cmin, m_cmax;

    function automatic int clamp_size(logic [8:0] v);
        if (v < 1) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] covar(logic [63:0] a, logic [63:0] s2,
                                                 logic [63:0] sa, logic [63:0] sb);
        logic [63:0] p, q, m, d;
        logic neg;
        p = a * s2;
        q = sa * sb;
        neg = p < q;
        m = neg ? q - p : p - q;
        d = a * a;
        if (d == 0) d = 1;
        m = (m << 16) / d;
        if (m > COV_SAT) m = COV_SAT;
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [63:0] mag(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [17:0] axis_len(logic [63:0] l2);
        logic [63:0] v;
        v = isqrt(6 * l2) + 128;
        return v > 262143 ? 18'h3FFFF : v[17:0];
    endfunction

    function automatic t_stats frame_result();
        t_stats s;
        logic [63:0] a, v, f, tr, lmax2, lmin2, dd, mxy;
        logic signed [63:0] cxx, cyy, cxy, x, y, z, t, xs, ys;
        s = '{default: '0};
        a = m_count;
        s.area = a > 131071 ? 17'h1FFFF : a[16:0];
        if (a == 0) return s;
        s.found = 1'b1;
        v = (m_rsum * 512 + a) / (2 * a);
        s.crow = v > 65535 ? 16'hFFFF : v[15:0];
        v = (m_csum * 512 + a) / (2 * a);
        s.ccol = v > 65535 ? 16'hFFFF : v[15:0];
        s.rmin = m_rmin;
        s.rmax = m_rmax;
        s.cmin = m_cmin;
        s.cmax = m_cmax;
        cxx = covar(a, m_rsq, m_rsum, m_rsum);
        cyy = covar(a, m_csq, m_csum, m_csum);
        cxy = covar(a, m_xsum, m_rsum, m_csum);
        if (cxx < 0) cxx = 0;
        if (cyy < 0) cyy = 0;
        dd = mag(cxx - cyy);
        mxy = mag(cxy);
        f = isqrt(dd * dd + 4 * mxy * mxy);
        tr = cxx + cyy;
        lmax2 = tr + f;
        lmin2 = tr > f ? tr - f : 0;
        s.major = axis_len(lmax2);
        s.minor = axis_len(lmin2);
        y = 2 * cyy - 2 * cxy - $signed(lmin2);
        x = 2 * cxx - 2 * cxy - $signed(lmin2);
        z = 0;
        if (x != 0 || y != 0) begin
            while (mag(x) < (64'd1 << 32) && mag(y) < (64'd1 << 32)) begin
                x = x * 2;
                y = y * 2;
            end
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = PI_HALF_Q16;
                end else begin
                    x = -y; y = t; z = -PI_HALF_Q16;
                end
            end
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys; y = y - xs; z = z + atan_q16(4'(i));
                end else begin
                    x = x - ys; y = y + xs; z = z - atan_q16(4'(i));
                end
            end
            z = (z + 4) >>> 3;
            if (z > ANGLE_MAX) z = ANGLE_MAX;
            if (z < -ANGLE_MAX) z = -ANGLE_MAX;
        end
        s.orient = z[15:0];
        return s;
    endfunction

    task automatic clear_stats();
        m_count = 0;
        m_rmin = 8'(clamp_size(m_rows) - 1);
        m_rmax = 0;
        m_cmin = 8'(clamp_size(m_cols) - 1);
        m_cmax = 0;
        m_rsum = 0; m_csum = 0; m_rsq = 0; m_csq = 0; m_xsum = 0;
    endtask

    task automatic reset_model();
        m_target = 8'd1;
        m_rows = 9'd256;
        m_cols = 9'd256;
        m_rfirst = 8'd0;
        m_rlast = 8'd255;
        m_cfirst = 8'd0;
        m_clast = 8'd255;
        m_row = 0;
        m_col = 0;
        clear_stats();
    endtask

    task automatic write_model_reg(logic [2:0] idx, logic [8:0] data);
        case (idx)
            CFG_TARGET_LABEL:  m_target = data[7:0];
            CFG_IMAGE_ROWS:    m_rows = data;
            CFG_IMAGE_COLS:    m_cols = data;
            CFG_BOX_ROW_FIRST: m_rfirst = data[7:0];
            CFG_BOX_ROW_LAST:  m_rlast = data[7:0];
            CFG_BOX_COL_FIRST: m_cfirst = data[7:0];
            CFG_BOX_COL_LAST:  m_clast = data[7:0];
            default: ;
        endcase
    endtask

    task automatic step_model(logic [7:0] lab);
        int nr, nc;
        nr = clamp_size(m_rows);
        nc = clamp_size(m_cols);
        if (lab == m_target && m_row >= m_rfirst && m_row <= m_rlast &&
            m_col >= m_cfirst && m_col <= m_clast) begin
            m_count++;
            if (m_row < m_rmin) m_rmin = 8'(m_row);
            if (m_row > m_rmax) m_rmax = 8'(m_row);
            if (m_col < m_cmin) m_cmin = 8'(m_col);
            if (m_col > m_cmax) m_cmax = 8'(m_col);
            m_rsum += m_row;
            m_csum += m_col;
            m_rsq += m_row * m_row;
            m_csq += m_col * m_col;
            m_xsum += m_row * m_col;
        end
        if (m_row >= nr - 1 && m_col >= nc - 1) begin
            frame_stats.push_back(frame_result());
            m_row = 0;
            m_col = 0;
            clear_stats();
        end else if (m_row >= nr - 1) begin
            m_row = 0;
            m_col++;
        end else begin
            m_row++;
        end
    endtask

    // driver
    int burst_left = 0, gap_left = 0, hold_left = 0;
    always @(posedge i_clk) begin
        logic nv, ncv;
        t_beat b;
        if (!i_rst_n) begin
            reset_model();
            i_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            nv = i_valid;
            ncv = i_cfg_valid;
            if (i_valid && !o_stall) begin
                step_model(i_pixel_label);
                nv = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                write_model_reg(i_cfg_index, i_cfg_data);
                ncv = 1'b0;
            end
            if (!nv && !ncv) begin
                if (hold_left > 0) begin
                    hold_left--;
                end else if (pending.size() > 0) begin
                    b = pending[0];
                    case (b.kind)
                        BEAT_PIXEL: begin
                            if (gap_left > 0) begin
                                gap_left--;
                            end else begin
                                void'(pending.pop_front());
                                i_pixel_label <= b.data[7:0];
                                nv = 1'b1;
                                if (burst_left > 0) begin
                                    burst_left--;
                                end else begin
                                    burst_left = $urandom_range(1, 40);
                                    gap_left = ($urandom_range(0, 3) == 0) ? 0
                                             : $urandom_range(1, 6);
                                end
                            end
                        end
                        BEAT_CFG: begin
                            void'(pending.pop_front());
                            i_cfg_index <= b.idx;
                            i_cfg_data <= b.data;
                            ncv = 1'b1;
                        end
                        default: begin
                            if (frame_stats.size() == 0) begin
                                void'(pending.pop_front());
                                hold_left = SETTLE;
                            end
                        end
                    endcase
                end
            end
            i_valid <= nv;
            i_cfg_valid <= ncv;
        end
    end

    // receiver stall pattern
    int stall_mode = 0, mode_left = 0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 1) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= ((cycles % 7) < 2);
        endcase
    end

    // monitor
    always @(posedge i_clk) begin
        t_stats e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (frame_stats.size() == 0) begin
                $display("%0t: unexpected beat area=%0d", $time, o_area);
                errors++;
            end else begin
                e = frame_stats.pop_front();
                if (o_blob_found !== e.found || o_area !== e.area ||
                    o_centroid_row !== e.crow || o_centroid_col !== e.ccol ||
                    o_min_row !== e.rmin || o_max_row !== e.rmax ||
                    o_min_col !== e.cmin || o_max_col !== e.cmax ||
                    o_major_axis !== e.major || o_minor_axis !== e.minor ||
                    o_orientation !== e.orient) begin
                    $display("%0t: expected %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                             $time, e.found, e.area, e.crow, e.ccol, e.rmin, e.rmax,
                             e.cmin, e.cmax, e.major, e.minor, e.orient);
                    $display("%0t: actual   %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                             $time, o_blob_found, o_area, o_centroid_row,
                             o_centroid_col, o_min_row, o_max_row, o_min_col,
                             o_max_col, o_major_axis, o_minor_axis, o_orientation);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("color_blob_moment_statistics: mismatch");
            $finish;
        end
    end

    int pixel_total = 0;

    task automatic add_cfg(logic [2:0] idx, logic [8:0] data);
        pending.push_back('{BEAT_CFG, idx, data});
    endtask

    // drain, then rewrite every register and queue frames of labels
    task automatic add_phase(logic [8:0] tgt, logic [8:0] rows, logic [8:0] cols,
                             logic [8:0] rf, logic [8:0] rl, logic [8:0] cf,
                             logic [8:0] cl, int frames, int hit_pct,
                             logic [7:0] other);
        int n;
        logic [7:0] lab;
        pending.push_back('{BEAT_DRAIN, 3'd0, 9'd0});
        add_cfg(CFG_TARGET_LABEL, tgt);
        add_cfg(CFG_IMAGE_ROWS, rows);
        add_cfg(CFG_IMAGE_COLS, cols);
        add_cfg(CFG_BOX_ROW_FIRST, rf);
        add_cfg(CFG_BOX_ROW_LAST, rl);
        add_cfg(CFG_BOX_COL_FIRST, cf);
        add_cfg(CFG_BOX_COL_LAST, cl);
        add_cfg(CFG_UNUSED, 9'($urandom_range(0, 511)));
        n = frames * clamp_size(rows) * clamp_size(cols);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < hit_pct) lab = tgt[7:0];
            else if (other != tgt[7:0]) lab = other;
            else lab = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0) lab = 8'($urandom_range(0, 255));
            pending.push_back('{BEAT_PIXEL, 3'd0, {1'b0, lab}});
        end
        pixel_total += n;
    endtask

    initial begin
        int rows, cols, frames;
        logic [8:0] tgt;
        // two single pixel frames, each a hit or empty at random; a hit has zero covariance
        add_phase(9'd0, 9'd1, 9'd1, 9'd0, 9'd255, 9'd0, 9'd255, 2, 50, 8'd255);
        // box with first past last
        add_phase(9'd255, 9'd2, 9'd2, 9'd1, 9'd0, 9'd0, 9'd255, 1, 100, 8'd0);
        // zero rows clamps to one
        add_phase(9'h1FF, 9'd0, 9'd3, 9'd0, 9'd255, 9'd0, 9'd255, 1, 70, 8'd0);
        add_phase(9'd128, 9'd3, 9'd3, 9'd0, 9'd2, 9'd1, 9'd2, 1, 60, 8'd127);
        // tall and wide extremes, oversize rows clamp to the maximum
        add_phase(9'd1, 9'd511, 9'd1, 9'd0, 9'd255, 9'd0, 9'd255, 1, 50, 8'd0);
        add_phase(9'd7, 9'd1, 9'd256, 9'd0, 9'd255, 9'd0, 9'd255, 1, 40, 8'd200);
        while (pixel_total < 1350) begin
            rows = $urandom_range(1, 10);
            cols = $urandom_range(1, 10);
            frames = $urandom_range(1, 5);
            if ($urandom_range(0, 19) == 0) rows = $urandom_range(0, 1) ? 0 : 300;
            if ($urandom_range(0, 19) == 0) cols = 0;
            // oversize rows keep one column and one frame
            if (rows > 10) begin
                cols = 1;
                frames = 1;
            end
            tgt = 9'($urandom_range(0, 511));
            add_phase(tgt, 9'(rows), 9'(cols), 9'($urandom_range(0, 511) % 8),
                      $urandom_range(0, 3) == 0 ? 9'h1FF : 9'($urandom_range(0, 12)),
                      9'($urandom_range(0, 511) % 8),
                      $urandom_range(0, 3) == 0 ? 9'h0FF : 9'($urandom_range(0, 12)),
                      frames, $urandom_range(0, 100),
                      8'($urandom_range(0, 255)));
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending.size() > 0 || i_valid || i_cfg_valid) @(posedge i_clk);
        while (frame_stats.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && frame_stats.size() == 0) begin
            $display("color_blob_moment_statistics: match");
        end else begin
            $display("color_blob_moment_statistics: mismatch");
        end
        $finish;
    end
endmodule
